// ----- hw/rtl/htw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// htw_pkg
// shared widths, codes and controller/datapath interface types for the
// hashed timing wheel
// ----------------------------------------------------------------------------
package htw_pkg;

    localparam int DELAY_W       = 16;
    localparam int ACTION_W      = 8;
    localparam int EVENT_W       = 2;
    localparam int IN_TDATA_W    = 24;
    localparam int OUT_TDATA_W   = 16;

    localparam int DEF_WHEEL_SLOTS   = 8;
    localparam int DEF_TIMER_ENTRIES = 16;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_ADD  = 1'b1;

    typedef enum logic [EVENT_W-1:0] {
        EV_ADD_OK    = 2'd0,
        EV_ADD_FULL  = 2'd1,
        EV_FIRED     = 2'd2,
        EV_TICK_DONE = 2'd3
    } t_event;

    // controller to datapath
    typedef struct packed {
        logic   latch_in;
        logic   add_start;
        logic   head_rd_add;
        logic   add_commit;
        logic   head_rd_tick;
        logic   walk_first;
        logic   walk_step;
        logic   cur_adv;
        logic   emit;
        t_event emit_ev;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic div_done;
        logic out_free;
        logic head_nil;
        logic rot_zero;
        logic nx_nil;
    } t_status;

endpackage

`default_nettype wire

// ----- hw/rtl/hashed_timing_wheel.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_timing_wheel
// hashed timing wheel: timers are hashed into slots by delay, a tick walks
// the current slot's list and fires the timers whose rotations ran out
// ----------------------------------------------------------------------------
// add: the item is latched, checked for a free entry, split into rotations and a slot
//   offset (reciprocal multiply, then remainder, if WHEEL_SLOTS is no power of two),
//   then the slot head is read and the entry linked in as its result beat is set
// tick: head read, then the list is walked, each link read giving the next address
// one item at a time; the next item is taken while the last result waits
// reset clears slot valid bits and the free list at once, no clearing pass
// ----------------------------------------------------------------------------
module hashed_timing_wheel #(
    parameter int WHEEL_SLOTS   = htw_pkg::DEF_WHEEL_SLOTS,
    parameter int TIMER_ENTRIES = htw_pkg::DEF_TIMER_ENTRIES
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input beats
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [htw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // delay, action_id
    input  wire logic                               s_axis_tuser,  // kind
    // result beats
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic      [htw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // event_res, fired_action, pad
    output logic                                    m_axis_tlast   // last
);

    localparam int DW = htw_pkg::DELAY_W;
    localparam int AW = htw_pkg::ACTION_W;
    localparam int EV = htw_pkg::EVENT_W;

    htw_pkg::t_cmd    cmd;
    htw_pkg::t_status st;
    htw_pkg::t_event  event_res;
    logic [AW-1:0]    fired_action;

    // sequencer: accepts a beat only when idle
    htw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // stores, divider, free list and the output register
    htw_datapath #(
        .WHEEL_SLOTS   (WHEEL_SLOTS),
        .TIMER_ENTRIES (TIMER_ENTRIES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_delay        (s_axis_tdata[DW-1:0]),
        .i_action       (s_axis_tdata[DW +: AW]),
        .i_out_ready    (m_axis_tready),
        .o_out_valid    (m_axis_tvalid),
        .o_event        (event_res),
        .o_fired_action (fired_action),
        .o_last         (m_axis_tlast)
    );

    // result packing, event code in the low bits
    assign m_axis_tdata = {{(htw_pkg::OUT_TDATA_W - EV - AW){1'b0}}, fired_action, event_res};

endmodule

`default_nettype wire

// ----- hw/rtl/htw_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// htw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/htw_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// htw_ctrl
// sequencer for add and tick operations of the timing wheel
// ----------------------------------------------------------------------------
module htw_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_kind,
    output logic                 o_in_ready,
    input  wire htw_pkg::t_status i_st,
    output htw_pkg::t_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_CHECK,
        S_ADD_DIV,
        S_ADD_LINK,
        S_TICK_FIRST,
        S_TICK_WALK,
        S_TICK_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.emit_ev = htw_pkg::EV_ADD_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    if (i_in_kind == htw_pkg::KIND_ADD) begin
                        n_state = S_ADD_CHECK;
                    end else begin
                        o_cmd.head_rd_tick = 1'b1;
                        n_state = S_TICK_FIRST;
                    end
                end
            end
            S_ADD_CHECK: begin
                if (i_st.full) begin
                    if (i_st.out_free) begin
                        o_cmd.emit    = 1'b1;
                        o_cmd.emit_ev = htw_pkg::EV_ADD_FULL;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.add_start = 1'b1;
                    n_state = S_ADD_DIV;
                end
            end
            S_ADD_DIV: begin
                if (i_st.div_done) begin
                    o_cmd.head_rd_add = 1'b1;
                    n_state = S_ADD_LINK;
                end
            end
            S_ADD_LINK: begin
                if (i_st.out_free) begin
                    o_cmd.add_commit = 1'b1;
                    o_cmd.emit       = 1'b1;
                    o_cmd.emit_ev    = htw_pkg::EV_ADD_OK;
                    n_state = S_IDLE;
                end
            end
            S_TICK_FIRST: begin
                if (i_st.head_nil) begin
                    n_state = S_TICK_DONE;
                end else begin
                    o_cmd.walk_first = 1'b1;
                    n_state = S_TICK_WALK;
                end
            end
            S_TICK_WALK: begin
                // an expiring entry needs room in the output register
                if (!i_st.rot_zero || i_st.out_free) begin
                    o_cmd.walk_step = 1'b1;
                    o_cmd.emit      = i_st.rot_zero;
                    o_cmd.emit_ev   = htw_pkg::EV_FIRED;
                    if (i_st.nx_nil) begin
                        n_state = S_TICK_DONE;
                    end
                end
            end
            S_TICK_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.emit_ev = htw_pkg::EV_TICK_DONE;
                    o_cmd.cur_adv = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/htw_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// htw_datapath
// slot heads, entry stores, free list, delay divider and result register
// ----------------------------------------------------------------------------
module htw_datapath #(
    parameter int WHEEL_SLOTS   = htw_pkg::DEF_WHEEL_SLOTS,
    parameter int TIMER_ENTRIES = htw_pkg::DEF_TIMER_ENTRIES
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire htw_pkg::t_cmd                 i_cmd,
    output htw_pkg::t_status                   o_st,
    input  wire logic [htw_pkg::DELAY_W-1:0]   i_delay,
    input  wire logic [htw_pkg::ACTION_W-1:0]  i_action,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output htw_pkg::t_event                    o_event,
    output logic      [htw_pkg::ACTION_W-1:0]  o_fired_action,
    output logic                               o_last
);

    localparam int DW  = htw_pkg::DELAY_W;
    localparam int AW  = htw_pkg::ACTION_W;
    localparam int SW  = $clog2(WHEEL_SLOTS);
    localparam int EW  = (TIMER_ENTRIES > 1) ? $clog2(TIMER_ENTRIES) : 1;
    localparam int LW  = $clog2(TIMER_ENTRIES + 1);
    localparam int RW  = $clog2(((1 << DW) - 1) / WHEEL_SLOTS + 1);
    localparam int EDW = RW + AW;
    localparam logic [LW-1:0]   NIL    = LW'(TIMER_ENTRIES);
    localparam logic [SW:0]     SLOTS  = (SW + 1)'(WHEEL_SLOTS);
    localparam logic [SW-1:0]   LAST_S = SW'(WHEEL_SLOTS - 1);

    // latched add item
    logic [DW-1:0] r_delay;
    logic [AW-1:0] r_act;

    // wheel position
    logic [SW-1:0] r_cur;

    // divider
    logic [DW-1:0] r_quo;
    logic [SW:0]   r_rem;
    logic          div_busy;

    // free list: never used entries by count, recycled ones on a stack
    logic [LW-1:0] r_sp;
    logic [LW-1:0] r_fresh;
    logic [EW-1:0] r_fresh_e;
    logic          r_use_stack;
    logic [LW-1:0] sp_m1;
    logic [EW-1:0] stack_rdata;
    logic [EW-1:0] e_new;

    // slot heads
    logic [WHEEL_SLOTS-1:0] r_head_vld;
    logic                   r_head_vq;
    logic [LW-1:0]          head_rdata;
    logic [LW-1:0]          head_e;
    logic [SW-1:0]          head_raddr;
    logic [SW-1:0]          head_waddr;
    logic [LW-1:0]          head_wdata;
    logic                   head_we;
    logic                   head_re;

    // walk
    logic [EW-1:0]  r_e;
    logic [EW-1:0]  r_prev;
    logic           r_prev_vld;
    logic [LW-1:0]  nx;
    logic [EDW-1:0] ent_rdata;
    logic [RW-1:0]  rot;
    logic [AW-1:0]  ent_act;
    logic           rot_zero;
    logic           fire;

    // entry stores
    logic           ent_re;
    logic [EW-1:0]  ent_raddr;
    logic           link_we;
    logic [EW-1:0]  link_waddr;
    logic [LW-1:0]  link_wdata;
    logic           ent_we;
    logic [EW-1:0]  ent_waddr;
    logic [EDW-1:0] ent_wdata;

    // target slot
    logic [SW:0]   pos_sum;
    logic [SW-1:0] pos;

    // result register
    logic r_ovalid;
    logic out_free;

    assign out_free = !r_ovalid || i_out_ready;

    assign pos_sum = (SW + 1)'(r_rem) + (SW + 1)'(r_cur);
    assign pos     = (pos_sum >= SLOTS) ? SW'(pos_sum - SLOTS) : pos_sum[SW-1:0];

    assign sp_m1  = r_sp - LW'(1);
    assign e_new  = r_use_stack ? stack_rdata : r_fresh_e;
    assign head_e = r_head_vq ? head_rdata : NIL;

    assign rot      = ent_rdata[AW +: RW];
    assign ent_act  = ent_rdata[AW-1:0];
    assign rot_zero = (rot == '0);
    assign fire     = i_cmd.walk_step && rot_zero;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_delay <= i_delay;
            r_act   <= i_action;
        end
    end

    // delay split into rotations and slot offset
    generate
        if ((WHEEL_SLOTS & (WHEEL_SLOTS - 1)) == 0) begin : g_div_pow2
            assign div_busy = 1'b0;
            always_ff @(posedge i_clk) begin
                if (i_cmd.add_start) begin
                    r_quo <= r_delay >> SW;
                    r_rem <= (SW + 1)'(r_delay[SW-1:0]);
                end
            end
        end else begin : g_div_recip
            localparam int RSH = DW + SW;
            localparam logic [DW:0] RECIP =
                (DW + 1)'(((1 << RSH) + WHEEL_SLOTS - 1) / WHEEL_SLOTS);
            logic          r_busy;
            logic [2*DW:0] prod;
            logic [DW-1:0] qd;

            assign prod     = (2*DW + 1)'(r_delay) * (2*DW + 1)'(RECIP);
            assign qd       = r_quo * DW'(WHEEL_SLOTS);
            assign div_busy = r_busy;

            // quotient by reciprocal multiply, remainder in the cycle after
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                end else begin
                    r_busy <= i_cmd.add_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.add_start) begin
                    r_quo <= DW'(prod[2*DW:RSH]);
                end
                if (r_busy) begin
                    r_rem <= r_delay[SW:0] - qd[SW:0];
                end
            end
        end
    endgenerate

    // free list and current slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp    <= '0;
            r_fresh <= '0;
            r_cur   <= '0;
        end else begin
            if (i_cmd.add_start) begin
                if (r_sp != '0) begin
                    r_sp <= sp_m1;
                end else begin
                    r_fresh <= r_fresh + LW'(1);
                end
            end else if (fire) begin
                r_sp <= r_sp + LW'(1);
            end
            if (i_cmd.cur_adv) begin
                r_cur <= (r_cur == LAST_S) ? '0 : r_cur + SW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_start) begin
            r_use_stack <= (r_sp != '0);
            r_fresh_e   <= r_fresh[EW-1:0];
        end
    end

    htw_ram #(
        .WIDTH (EW),
        .DEPTH (TIMER_ENTRIES)
    ) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (fire),
        .i_waddr (r_sp[EW-1:0]),
        .i_wdata (r_e),
        .i_re    (i_cmd.add_start && (r_sp != '0)),
        .i_raddr (sp_m1[EW-1:0]),
        .o_rdata (stack_rdata)
    );

    // slot head store, never written slots tracked by valid bits, emptied ones hold NIL
    assign head_re    = i_cmd.head_rd_add || i_cmd.head_rd_tick;
    assign head_raddr = i_cmd.head_rd_add ? pos : r_cur;
    assign head_we    = i_cmd.add_commit || (fire && !r_prev_vld);
    assign head_waddr = i_cmd.add_commit ? pos : r_cur;
    assign head_wdata = i_cmd.add_commit ? LW'(e_new) : nx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_vld <= '0;
        end else if (i_cmd.add_commit) begin
            r_head_vld[pos] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_re) begin
            r_head_vq <= r_head_vld[head_raddr];
        end
    end

    htw_ram #(
        .WIDTH (LW),
        .DEPTH (WHEEL_SLOTS)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_re    (head_re),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    // walk pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_vld <= 1'b0;
        end else if (i_cmd.head_rd_tick) begin
            r_prev_vld <= 1'b0;
        end else if (i_cmd.walk_step && !rot_zero) begin
            r_prev_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_first) begin
            r_e <= head_e[EW-1:0];
        end else if (i_cmd.walk_step) begin
            r_e <= nx[EW-1:0];
        end
        if (i_cmd.walk_step && !rot_zero) begin
            r_prev <= r_e;
        end
    end

    // entry stores, read address follows the link just read
    assign ent_re    = i_cmd.walk_first || (i_cmd.walk_step && (nx != NIL));
    assign ent_raddr = i_cmd.walk_first ? head_e[EW-1:0] : nx[EW-1:0];

    assign link_we    = i_cmd.add_commit || (fire && r_prev_vld);
    assign link_waddr = i_cmd.add_commit ? e_new : r_prev;
    assign link_wdata = i_cmd.add_commit ? head_e : nx;

    assign ent_we    = i_cmd.add_commit || (i_cmd.walk_step && !rot_zero);
    assign ent_waddr = i_cmd.add_commit ? e_new : r_e;
    assign ent_wdata = i_cmd.add_commit ? {RW'(r_quo), r_act} : {rot - RW'(1), ent_act};

    htw_ram #(
        .WIDTH (LW),
        .DEPTH (TIMER_ENTRIES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (nx)
    );

    htw_ram #(
        .WIDTH (EDW),
        .DEPTH (TIMER_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_event        <= i_cmd.emit_ev;
            o_fired_action <= (i_cmd.emit_ev == htw_pkg::EV_FIRED) ? ent_act : '0;
            o_last         <= (i_cmd.emit_ev != htw_pkg::EV_FIRED);
        end
    end

    assign o_out_valid = r_ovalid;

    assign o_st.full     = (r_sp == '0) && (r_fresh == NIL);
    assign o_st.div_done = !div_busy;
    assign o_st.out_free = out_free;
    assign o_st.head_nil = (head_e == NIL);
    assign o_st.rot_zero = rot_zero;
    assign o_st.nx_nil   = (nx == NIL);

endmodule

`default_nettype wire
